// ===== rtl/core/srv_pkg.sv =====
// Package for the Schroeder reverb core: widths, depths, FSM state type and helpers.
// Depends on nothing; used by schroeder_reverb_top.
package srv_pkg;
   localparam int COMB_DEPTH  = 4096;
   localparam int STATE_WIDTH = 24;
   localparam int AP_SHORT    = 225;
   localparam int AP_LONG     = 556;
   localparam int COMB_AW     = $clog2(COMB_DEPTH);
   localparam int COMB_MEM_AW = COMB_AW + 2;
   localparam int APS_AW      = $clog2(AP_SHORT);
   localparam int APL_AW      = $clog2(AP_LONG);
   localparam int CNT_W       = 12;
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic [7:0] ROOM_RESET = 8'd108;
   localparam logic [7:0] WET_RESET  = 8'd46;
   localparam logic [7:0] WET_MIN    = 8'd3;
   localparam logic CSR_ROOM = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CRD, ST_CWAIT, ST_CMUL, ST_CWR, ST_SUM,
      ST_ARD, ST_AWAIT, ST_AWR, ST_MIX, ST_OUT
   } state_type;

   // Saturate a wide value to the state width.
   function automatic logic signed [STATE_WIDTH-1:0] sat_state(input logic signed [47:0] v);
      logic signed [47:0] hi;
      logic signed [47:0] lo;
      hi = (48'sd1 <<< (STATE_WIDTH-1)) - 48'sd1;
      lo = -hi - 48'sd1;
      if (v > hi) sat_state = hi[STATE_WIDTH-1:0];
      else if (v < lo) sat_state = lo[STATE_WIDTH-1:0];
      else sat_state = v[STATE_WIDTH-1:0];
   endfunction

   // Comb base delay for each of the four combs.
   function automatic logic [11:0] comb_base(input logic [1:0] c);
      unique case (c)
         2'd0: comb_base = 12'd1557;
         2'd1: comb_base = 12'd1617;
         2'd2: comb_base = 12'd1491;
         default: comb_base = 12'd1422;
      endcase
   endfunction
endpackage

// ===== rtl/core/schroeder_reverb_top.sv =====
// Schroeder reverb top level: sequencer, shared multiply-add unit and delay memories.
// Depends on srv_pkg and srv_ram.
//
//  channel | valid     | flow      | payload
//  req     | req_valid | req_stall | req_sample_in, req_first
//  rsp     | rsp_valid | rsp_stall | rsp_sample_out
//  csr     | csr_valid | csr_ready | csr_index, csr_data
//
// Each transaction runs through four combs, each stepping through read, wait,
// multiply and write on one comb RAM port and one multiplier, then a sum step,
// two allpasses each stepping through read, wait and write, and a mix step. The
// result is then offered, and a new sample is accepted only once it is taken.
// No clearing pass is needed; reset is synchronous.
// req_stall is high while a sample is in work or its result waits on rsp_stall.
module schroeder_reverb_top import srv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample_in,
   input  logic               req_first,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_sample_out,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [7:0]         csr_data
);
   localparam int SW = STATE_WIDTH;

   state_type state_ff, state_in;
   logic [7:0] room_ff, wet_ff;
   logic [1:0] comb_ff;
   logic       ap_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [COMB_AW-1:0] cwr_ff;
   logic [APS_AW-1:0] swr_ff;
   logic [APL_AW-1:0] lwr_ff;
   logic signed [15:0] x_ff;
   logic signed [SW+3:0] sum_ff;
   logic signed [SW-1:0] acc_ff;
   logic signed [47:0] prod_ff;
   logic signed [15:0] out_ff;

   // Derived coefficients from room size, computed combinationally.
   logic [16:0] scale;
   logic [28:0] dprod;
   logic [12:0] dly;
   logic [11:0] delay;
   logic [16:0] gain;
   always_comb begin
      scale = 17'd49152 + 17'(({17'd0, room_ff} * 25'd42598) >> 8);
      dprod = 29'(comb_base(comb_ff)) * 29'(scale);
      dly = 13'(dprod >> 16);
      if (dly < 13'd1) dly = 13'd1;
      if (dly > 13'(COMB_DEPTH-1)) dly = 13'(COMB_DEPTH-1);
      delay = dly[11:0];
      gain = 17'(32768 + ((27525 * {9'd0, room_ff}) >> 8));
   end

   // Memory ports.
   logic c_we, s_we, l_we;
   logic [COMB_MEM_AW-1:0] c_addr;
   logic [SW-1:0] c_rd, s_rd, l_rd, wdata;
   logic [COMB_AW-1:0] c_rda;
   assign c_rda = cwr_ff - COMB_AW'(delay);
   assign c_addr = {comb_ff, (state_ff == ST_CWR) ? cwr_ff : c_rda};
   srv_ram #(.WIDTH(SW), .DEPTH(4*COMB_DEPTH)) u_comb (
      .clock(clock), .we(c_we), .addr(c_addr), .wdata(wdata), .rdata(c_rd));
   srv_ram #(.WIDTH(SW), .DEPTH(AP_SHORT)) u_aps (
      .clock(clock), .we(s_we), .addr(swr_ff), .wdata(wdata), .rdata(s_rd));
   srv_ram #(.WIDTH(SW), .DEPTH(AP_LONG)) u_apl (
      .clock(clock), .we(l_we), .addr(lwr_ff), .wdata(wdata), .rdata(l_rd));

   // Shared datapath terms.
   logic signed [SW-1:0] bo;
   logic signed [SW-1:0] cv, av;
   logic signed [SW-1:0] ap_out;
   logic comb_ok, ap_ok;
   assign comb_ok = {1'b0, cnt_ff} >= {1'b0, delay};
   assign ap_ok = ap_ff ? (cnt_ff >= CNT_W'(AP_LONG)) : (cnt_ff >= CNT_W'(AP_SHORT));
   assign bo = !ap_ok ? '0 : (ap_ff ? $signed(l_rd) : $signed(s_rd));
   assign cv = sat_state(48'(x_ff) + (prod_ff >>> 16));
   assign av = sat_state(48'(acc_ff) - 48'(bo >>> 1));
   assign ap_out = sat_state(48'(bo) + 48'(av >>> 1));
   assign wdata = (state_ff == ST_CWR) ? cv : av;

   // Mix terms.
   logic signed [47:0] p, pc;
   logic [47:0] mag;
   logic [63:0] mscaled;
   logic signed [15:0] mixv;
   always_comb begin
      p = 48'(x_ff) * (48'sd65536 - 48'($signed({1'b0, wet_ff, 8'd0})))
        + 48'(acc_ff) * 48'($signed({1'b0, wet_ff, 8'd0}));
      pc = p;
      if (p > (48'sd1 <<< 31)) pc = 48'sd1 <<< 31;
      if (p < -(48'sd1 <<< 31)) pc = -(48'sd1 <<< 31);
      mag = pc[47] ? 48'(-pc) : 48'(pc);
      mscaled = (64'(mag) * 64'd32767) >> 31;
      mixv = pc[47] ? -16'(mscaled) : 16'(mscaled);
      if (wet_ff < WET_MIN) mixv = x_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CRD;
         ST_CRD:   state_in = ST_CWAIT;
         ST_CWAIT: state_in = ST_CMUL;
         ST_CMUL:  state_in = ST_CWR;
         ST_CWR:   state_in = (comb_ff == 2'd3) ? ST_SUM : ST_CRD;
         ST_SUM:   state_in = ST_ARD;
         ST_ARD:   state_in = ST_AWAIT;
         ST_AWAIT: state_in = ST_AWR;
         ST_AWR:   state_in = ap_ff ? ST_MIX : ST_ARD;
         ST_MIX:   state_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_stall = state_ff != ST_IDLE;
      rsp_valid = state_ff == ST_OUT;
      csr_ready = state_ff == ST_IDLE;
      c_we = state_ff == ST_CWR;
      s_we = (state_ff == ST_AWR) && !ap_ff;
      l_we = (state_ff == ST_AWR) && ap_ff;
   end
   assign rsp_sample_out = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         room_ff <= ROOM_RESET;
         wet_ff <= WET_RESET;
         cnt_ff <= '0;
         cwr_ff <= '0;
         swr_ff <= '0;
         lwr_ff <= '0;
         comb_ff <= '0;
         ap_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ROOM) room_ff <= csr_data;
            else wet_ff <= csr_data;
         end
         if (state_ff == ST_IDLE && req_valid) begin
            comb_ff <= '0;
            ap_ff <= 1'b0;
            if (req_first) cnt_ff <= '0;
         end
         if (state_ff == ST_CWR) comb_ff <= comb_ff + 2'd1;
         if (state_ff == ST_AWR) begin
            ap_ff <= 1'b1;
            if (ap_ff) lwr_ff <= (lwr_ff == APL_AW'(AP_LONG-1)) ? '0 : lwr_ff + 1'b1;
            else swr_ff <= (swr_ff == APS_AW'(AP_SHORT-1)) ? '0 : swr_ff + 1'b1;
         end
         if (state_ff == ST_MIX) begin
            cwr_ff <= cwr_ff + 1'b1;
            if (cnt_ff != COUNT_MAX) cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         x_ff <= req_sample_in;
         sum_ff <= '0;
      end
      if (state_ff == ST_CWAIT)
         prod_ff <= comb_ok ? 48'($signed(c_rd)) * 48'($signed({1'b0, gain[15:0]})) : '0;
      if (state_ff == ST_CWR) sum_ff <= sum_ff + (SW+4)'(cv);
      if (state_ff == ST_SUM) acc_ff <= sat_state(48'(sum_ff >>> 2));
      if (state_ff == ST_AWR) acc_ff <= ap_out;
      if (state_ff == ST_MIX) out_ff <= mixv;
   end

   // Assertions.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accepted input while result pending");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample_out))
      else $error("result changed under stall");
   a_we: assert property (@(posedge clock) disable iff (reset)
      $onehot0({c_we, s_we, l_we})) else $error("two memory writes at once");
   a_csr: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !rsp_valid) else $error("config open while busy");
endmodule

// ===== rtl/core/srv_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
module srv_ram #(parameter int WIDTH = 24, parameter int DEPTH = 256) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
